// ----- hdl/palette_nearest_match_insert_macros.svh -----
// Assertion macros for the palette nearest-match block.
// Used by the checker module; needs clk and rst_n in the scope of each use.
`ifndef PALETTE_NEAREST_MATCH_INSERT_MACROS_SVH
`define PALETTE_NEAREST_MATCH_INSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNMI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNMI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pnmi_pkg.sv -----
// Shared types, constants and helper functions of the palette nearest-match block.
// No dependencies; imported by every module of the block.
package pnmi_pkg;

  // Sizes fixed by the item fields.
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 8;
  localparam int REQ_W             = 2;
  localparam int DIST_W            = 10;
  localparam int THR_W             = 10;
  localparam int INDEX_W           = 8;
  localparam int IN_DATA_W         = 24;
  localparam int OUT_DATA_W        = 48;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int QUEUE_DEPTH       = 2;

  // Distance reported when a match finds no entry at all.
  localparam logic [DIST_W-1:0] EMPTY_DISTANCE  = 10'd768;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 10'd3;

  // Register index of the threshold (byte address divided by four).
  localparam logic [CFG_ADDR_W-3:0] REG_IDX_THRESHOLD = 1'b0;

  // Request codes as they arrive on the input channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_MATCH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  // Commands handed from the front end to the execution unit.
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_MATCH,
    CMD_NOP
  } cmd_kind_t;

  // Execution unit states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE
  } back_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    cmd_kind_t kind;
    rgb_t      color;
  } cmd_t;

  // Queue status seen by both the front end and the execution unit.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    rgb_t               color;
    logic [INDEX_W-1:0] entry_index;
    logic               added;
    logic               palette_full;
    logic [DIST_W-1:0]  nearest_distance;
  } result_t;

  // Absolute difference of two color components.
  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Manhattan distance between two colors; at most 765.
  function automatic logic [DIST_W-1:0] color_distance(input rgb_t a, input rgb_t b);
    return DIST_W'(abs_diff(a.red, b.red)) + DIST_W'(abs_diff(a.green, b.green))
         + DIST_W'(abs_diff(a.blue, b.blue));
  endfunction

endpackage

// ----- hdl/pnmi_front.sv -----
// Front end: accepts input beats and classifies the request code into a command.
// Depends on pnmi_pkg; feeds pnmi_queue.
module pnmi_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pnmi_pkg::IN_DATA_W-1:0]  in_tdata,   // in_red, in_green, in_blue
  input  logic [pnmi_pkg::REQ_W-1:0]      in_tuser,   // req_type
  input  pnmi_pkg::q_status_t             q_status,
  output logic                            push,
  output pnmi_pkg::cmd_t                  push_cmd
);
  import pnmi_pkg::*;

  // A beat is taken whenever the queue has room.
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  // Unpack the color, lowest field in the lowest bits.
  always_comb begin
    push_cmd.color.red   = in_tdata[COLOR_W-1:0];
    push_cmd.color.green = in_tdata[2*COLOR_W-1:COLOR_W];
    push_cmd.color.blue  = in_tdata[3*COLOR_W-1:2*COLOR_W];
  end

  // Map the request code to a command.
  always_comb begin
    unique case (req_code_t'(in_tuser))
      REQ_CLEAR:  push_cmd.kind = CMD_CLEAR;
      REQ_APPEND: push_cmd.kind = CMD_APPEND;
      REQ_MATCH:  push_cmd.kind = CMD_MATCH;
      default:    push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ----- hdl/pnmi_queue.sv -----
// Short command queue between the front end and the execution unit.
// Depends on pnmi_pkg for the command type and depth.
module pnmi_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pnmi_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output pnmi_pkg::cmd_t       head_cmd,
  output pnmi_pkg::q_status_t  status
);
  import pnmi_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign status.full  = (fill_r == FILL_MAX);
  assign status.empty = (fill_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = slots[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + QW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + QW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/pnmi_back.sv -----
// Execution unit: palette memory, entry count, sequential nearest-entry scan and
// the registered result slot. Depends on pnmi_pkg; pops commands from pnmi_queue.
module pnmi_back #(
  parameter int PALETTE_DEPTH = pnmi_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pnmi_pkg::cmd_t               head_cmd,
  input  pnmi_pkg::q_status_t          q_status,
  output logic                         pop,
  input  logic [pnmi_pkg::THR_W-1:0]   threshold,
  output pnmi_pkg::result_t            res,
  output logic                         res_valid,
  input  logic                         res_ready
);
  import pnmi_pkg::*;

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  result_t           res_r, res_nxt;
  logic              res_valid_r;
  logic              load_res;
  logic              slot_free;
  logic              full;

  // Scan datapath.
  cmd_t              cmd_r;
  logic [CNT_W-1:0]  issue_cnt_r;
  logic              issuing;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  rgb_t              rd_data_r;
  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  rgb_t              best_color_r;
  logic              start_scan;

  // Palette memory ports.
  rgb_t              palette_mem [PALETTE_DEPTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  rgb_t              mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  assign slot_free = !res_valid_r || res_ready;
  assign full      = (count_r == DEPTH_CNT);
  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign mem_raddr = issue_cnt_r[IDX_W-1:0];
  assign cand_dist = color_distance(rd_data_r, cmd_r.color);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty && slot_free && head_cmd.kind == CMD_MATCH &&
            count_r != '0) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (issue_cnt_r == count_r && !rd_vld_r) begin
          state_nxt = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the state machine: queue pop, memory write, count and result.
  always_comb begin
    pop        = 1'b0;
    start_scan = 1'b0;
    issuing    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = count_r[IDX_W-1:0];
    mem_wdata  = head_cmd.color;
    count_nxt  = count_r;
    load_res   = 1'b0;
    res_nxt    = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty && slot_free) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            CMD_CLEAR: begin
              count_nxt = '0;
              load_res  = 1'b1;
            end
            CMD_APPEND: begin
              load_res      = 1'b1;
              res_nxt.color = head_cmd.color;
              if (!full) begin
                mem_we              = 1'b1;
                count_nxt           = count_r + CNT_W'(1);
                res_nxt.entry_index = INDEX_W'(count_r);
                res_nxt.added       = 1'b1;
                res_nxt.palette_full = (count_nxt == DEPTH_CNT);
              end else begin
                res_nxt.palette_full = 1'b1;
              end
            end
            CMD_MATCH: begin
              if (count_r == '0) begin
                // Empty palette: the color is always added.
                mem_we                   = 1'b1;
                count_nxt                = CNT_W'(1);
                load_res                 = 1'b1;
                res_nxt.color            = head_cmd.color;
                res_nxt.added            = 1'b1;
                res_nxt.palette_full     = (count_nxt == DEPTH_CNT);
                res_nxt.nearest_distance = EMPTY_DISTANCE;
              end else begin
                start_scan = 1'b1;
              end
            end
            default: begin
              load_res             = 1'b1;
              res_nxt.palette_full = full;
            end
          endcase
        end
      end
      BK_SCAN: begin
        issuing = (issue_cnt_r < count_r);
      end
      BK_DECIDE: begin
        if (slot_free) begin
          load_res                 = 1'b1;
          res_nxt.nearest_distance = best_dist_r;
          if (best_dist_r <= threshold || full) begin
            res_nxt.color        = best_color_r;
            res_nxt.entry_index  = INDEX_W'(best_idx_r);
            res_nxt.palette_full = full;
          end else begin
            // No entry close enough and room left: insert the request color.
            mem_we               = 1'b1;
            mem_wdata            = cmd_r.color;
            count_nxt            = count_r + CNT_W'(1);
            res_nxt.color        = cmd_r.color;
            res_nxt.entry_index  = INDEX_W'(count_r);
            res_nxt.added        = 1'b1;
            res_nxt.palette_full = (count_nxt == DEPTH_CNT);
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= issuing;
      if (load_res) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  // Scan bookkeeping: read pipeline and running minimum, ties keep the lower index.
  always_ff @(posedge clk) begin
    if (start_scan) begin
      cmd_r       <= head_cmd;
      issue_cnt_r <= '0;
      best_dist_r <= EMPTY_DISTANCE;
      best_idx_r  <= '0;
    end else begin
      if (issuing) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
      end
      if (rd_vld_r && cand_dist < best_dist_r) begin
        best_dist_r  <= cand_dist;
        best_idx_r   <= rd_idx_r;
        best_color_r <= rd_data_r;
      end
    end
    rd_idx_r <= mem_raddr;
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= palette_mem[mem_raddr];
  end

endmodule

// ----- hdl/palette_nearest_match_insert.sv -----
// Palette nearest-color match or insert: usage notes.
// Input channel (in_): one beat per request; in_tuser carries the request kind
// (clear, append, match or insert), in_tdata the color. A short command queue
// takes beats while the execution unit is busy, so in_tready drops only when it fills.
// Result channel (out_): exactly one beat per request, in request order.
// Configuration port (cfg_): APB-style, one register, the match threshold at byte
// address 0, reset value 3. Write it only while no request is outstanding.
// Timing: clear, append, unused requests and a match on an empty palette pass
// through the queue register and then the result register. A match instead holds
// the execution unit while it scans the stored entries, reading the palette memory
// one entry per cycle on its single read port, and then decides and loads its result.
// Requests are carried out one at a time.
// Reset (synchronous, rst_n low) empties the palette, empties the queue, drops
// out_tvalid and sets the threshold to 3. Palette contents are not cleared.
// When the receiver holds out_tready low the result stays registered and stable;
// the unit stops once its result slot is full, and the queue absorbs up to two
// more requests before in_tready falls.
module palette_nearest_match_insert #(
  parameter int PALETTE_DEPTH = pnmi_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pnmi_pkg::IN_DATA_W-1:0]   in_tdata,   // in_red, in_green, in_blue
  input  logic [pnmi_pkg::REQ_W-1:0]       in_tuser,   // req_type
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_red, out_green, out_blue, entry_index, added, palette_full,
  // nearest_distance, zero fill
  output logic [pnmi_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pnmi_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pnmi_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pnmi_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import pnmi_pkg::*;

  localparam int PAD_W = OUT_DATA_W - (4 * COLOR_W + 2 + DIST_W);

  logic [THR_W-1:0] threshold_r;
  logic             cfg_sel_thr;
  logic             push;
  logic             pop;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  q_status_t        q_status;
  result_t          res;

  // Configuration register: written in the access phase, read back at any time.
  assign cfg_pready  = 1'b1;
  assign cfg_sel_thr = (cfg_paddr[CFG_ADDR_W-1:2] == REG_IDX_THRESHOLD);
  assign cfg_prdata  = cfg_sel_thr ? CFG_DATA_W'(threshold_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_thr) begin
      threshold_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  pnmi_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pnmi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  pnmi_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .threshold (threshold_r),
    .res       (res),
    .res_valid (out_tvalid),
    .res_ready (out_tready)
  );

  // Pack the result, first field in the lowest bits.
  assign out_tdata = {PAD_W'(0), res.nearest_distance, res.palette_full, res.added,
                      res.entry_index, res.color.blue, res.color.green, res.color.red};

endmodule

// ----- hdl/pnmi_checker.sv -----
// Port-level checker for the palette nearest-match block, bound to the top level.
// Depends on pnmi_pkg and the assertion macros header.
`include "palette_nearest_match_insert_macros.svh"

module pnmi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pnmi_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pnmi_pkg::*;

  logic [2:0]        pend_r;
  logic [DIST_W-1:0] near_dist;
  logic              added;
  logic [INDEX_W-1:0] index;

  assign near_dist = out_tdata[4*COLOR_W+2+DIST_W-1:4*COLOR_W+2];
  assign added     = out_tdata[4*COLOR_W];
  assign index     = out_tdata[4*COLOR_W-1:3*COLOR_W];

  // Requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_tvalid && in_tready) - 3'(out_tvalid && out_tready);
    end
  end

  `PNMI_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `PNMI_ASSERT_IMP(a_no_orphan, out_tvalid, pend_r != 3'd0,
                   "result beat without an outstanding request")
  `PNMI_ASSERT_IMP(a_dist_range, out_tvalid, near_dist <= EMPTY_DISTANCE,
                   "nearest distance out of range")
  `PNMI_ASSERT_IMP(a_empty_adds, out_tvalid && near_dist == EMPTY_DISTANCE,
                   added && index == '0, "match on empty palette did not add at entry 0")

endmodule

bind palette_nearest_match_insert pnmi_checker u_checker (.*);
